@@ src/txcon_pkg.sv @@
// Shared types and constants for the text console cursor/scroll engine.
// Holds field widths, operation codes, control bytes and the blank cell.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package txcon_pkg;

    // Field widths of the item and result beats
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;

    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [OP_W-1:0]   t_op;

    // Operation codes
    localparam t_op OP_PUT    = 2'd0;
    localparam t_op OP_PUT_AT = 2'd1;
    localparam t_op OP_CLEAR  = 2'd2;
    localparam t_op OP_READ   = 2'd3;

    // Control and printable character bytes
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    // White on black space
    localparam t_cell BLANK_CELL = 16'h0F20;

endpackage

`default_nettype wire

@@ src/text_console_cursor_scroll.sv @@
// Text console engine top level: cursor control, scroll and the screen store.
// Depends on txcon_pkg and txcon_ram.
//
//   channel  direction  handshake          payload
//   item     in         i_valid / o_stall  i_operation i_char_code i_attribute i_column i_row
//   result   out        o_valid / i_stall  o_cursor_col_out o_cursor_row_out
//                                          o_cursor_location o_read_cell
//
// A put or put-at goes through S_EXEC and S_FIN; a read adds S_READ for the registered RAM read,
// an off-screen read goes through S_EXEC and S_FIN. A put that scrolls adds an S_SWEEP of COLUMNS
// cells: the screen rows form a ring, so a scroll only moves the top-row pointer and blanks one row
// through the single write port. A clear sweeps all COLUMNS * ROWS cells, one cell written per cycle.
// After reset the store is blanked the same way (2000 cells with the defaults), with o_stall high.
// The next item is taken while a result waits in the output register; a result that finds the
// output still full holds the block until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll
    import txcon_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic [ATTR_W-1:0] i_attribute,
    input  wire logic [COL_W-1:0]  i_column,
    input  wire logic [ROW_W-1:0]  i_row,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [COL_W-1:0]       o_cursor_col_out,
    output logic [ROW_W-1:0]       o_cursor_row_out,
    output logic [LOC_W-1:0]       o_cursor_location,
    output logic [CELL_W-1:0]      o_read_cell
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    // Sequencer states
    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // Next tab stop for every column, built at elaboration
    typedef logic [COLUMNS-1:0][7:0] t_tab_tbl;

    function automatic t_tab_tbl f_tab_table();
        t_tab_tbl tbl;
        int       stop;
        stop = TAB_STOP;
        for (int c = 0; c < COLUMNS; c++) begin
            if (c >= stop) begin
                stop = stop + TAB_STOP;
            end
            tbl[c] = 8'(stop);
        end
        return tbl;
    endfunction

    localparam t_tab_tbl TAB_NEXT = f_tab_table();

    // Control registers
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [RW-1:0] r_top, n_top;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_last, n_last;
    logic          r_item, n_item;
    logic          r_out_valid, n_out_valid;

    // Payload registers
    t_op               r_op, n_op;
    logic [CHAR_W-1:0] r_ch, n_ch;
    logic [ATTR_W-1:0] r_attr, n_attr;
    logic [COL_W-1:0]  r_col_in, n_col_in;
    logic [ROW_W-1:0]  r_row_in, n_row_in;
    t_cell             r_cell, n_cell;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [LOC_W-1:0]  r_out_loc, n_out_loc;
    t_cell             r_out_cell, n_out_cell;

    // Datapath nets
    logic          w_out_free;
    logic          w_in_acc;
    logic          w_col_ok;
    logic          w_row_ok;
    logic [CW-1:0] w_bc;
    logic [RW-1:0] w_br;
    logic [RW:0]   w_prow_sum;
    logic [RW-1:0] w_prow;
    logic [AW-1:0] w_addr;
    logic [AW-1:0] w_top_base;
    logic [RW-1:0] w_top_next;
    logic          w_is_print;
    logic [7:0]    w_nc;
    logic [RW:0]   w_nr;
    logic          w_wr_cell;
    logic          w_scroll;
    logic [AW-1:0] w_loc;

    // RAM port nets
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    t_cell         w_ram_wdata;
    logic          w_ram_re;
    t_cell         w_ram_rdata;

    // Handshake
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) || ((r_state == S_FIN) && w_out_free));
    assign w_in_acc   = i_valid && !o_stall;

    // Clamp the position from the item, pick the working cursor
    assign w_col_ok = ({1'b0, r_col_in} < 8'(COLUMNS));
    assign w_row_ok = ({2'b00, r_row_in} < 7'(ROWS));
    assign w_bc = (r_op == OP_PUT) ? r_cur_col :
                  (w_col_ok ? CW'(r_col_in) : CW'(COLUMNS - 1));
    assign w_br = (r_op == OP_PUT) ? r_cur_row :
                  (w_row_ok ? RW'(r_row_in) : RW'(ROWS - 1));

    // Map logical row to physical row through the ring offset
    assign w_prow_sum = {1'b0, w_br} + {1'b0, r_top};
    assign w_prow = (w_prow_sum >= (RW+1)'(ROWS)) ? RW'(w_prow_sum - (RW+1)'(ROWS))
                                                  : RW'(w_prow_sum);
    assign w_addr     = AW'(w_prow) * AW'(COLUMNS) + AW'(w_bc);
    assign w_top_base = AW'(r_top) * AW'(COLUMNS);
    assign w_top_next = (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);

    assign w_is_print = r_ch inside {[CH_PRINT_LO:CH_PRINT_HI]};

    // Advance the cursor for one put byte
    always_comb begin
        w_nc      = 8'(w_bc);
        w_nr      = {1'b0, w_br};
        w_wr_cell = 1'b0;
        if ((r_ch == CH_BS) && (w_bc != '0)) begin
            w_nc = 8'(w_bc) - 8'd1;
        end else if (r_ch == CH_TAB) begin
            w_nc = TAB_NEXT[w_bc];
        end else if (r_ch == CH_CR) begin
            w_nc = '0;
        end else if (r_ch == CH_LF) begin
            w_nc = '0;
            w_nr = w_nr + (RW+1)'(1);
        end else if (w_is_print) begin
            w_wr_cell = 1'b1;
            w_nc      = w_nc + 8'd1;
        end
        // Wrap past the last column
        if (w_nc >= 8'(COLUMNS)) begin
            w_nc = '0;
            w_nr = w_nr + (RW+1)'(1);
        end
    end

    assign w_scroll = (w_nr >= (RW+1)'(ROWS));

    // Linear cursor location for the result beat
    assign w_loc = AW'(r_cur_row) * AW'(COLUMNS) + AW'(r_cur_col);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_top       = r_top;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_last      = r_last;
        n_item      = r_item;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_ch        = r_ch;
        n_attr      = r_attr;
        n_col_in    = r_col_in;
        n_row_in    = r_row_in;
        n_cell      = r_cell;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_loc   = r_out_loc;
        n_out_cell  = r_out_cell;
        w_ram_we    = 1'b0;
        w_ram_waddr = w_addr;
        w_ram_wdata = {r_attr, r_ch};
        w_ram_re    = 1'b0;

        // Drop the result once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                // Blank one cell per cycle
                w_ram_we    = 1'b1;
                w_ram_waddr = r_base + r_cnt;
                w_ram_wdata = BLANK_CELL;
                if (r_cnt == r_last) begin
                    n_cnt   = '0;
                    n_state = r_item ? S_FIN : S_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_EXEC: begin
                n_cell = '0;
                case (r_op)
                    OP_PUT, OP_PUT_AT: begin
                        w_ram_we  = w_wr_cell;
                        n_cur_col = CW'(w_nc);
                        if (w_scroll) begin
                            // Rotate the ring and blank the old top row
                            n_cur_row = RW'(ROWS - 1);
                            n_top     = w_top_next;
                            n_base    = w_top_base;
                            n_last    = AW'(COLUMNS - 1);
                            n_cnt     = '0;
                            n_item    = 1'b1;
                            n_state   = S_SWEEP;
                        end else begin
                            n_cur_row = RW'(w_nr);
                            n_state   = S_FIN;
                        end
                    end
                    OP_CLEAR: begin
                        n_cur_col = '0;
                        n_cur_row = '0;
                        n_top     = '0;
                        n_base    = '0;
                        n_last    = AW'(CELLS - 1);
                        n_cnt     = '0;
                        n_item    = 1'b1;
                        n_state   = S_SWEEP;
                    end
                    OP_READ: begin
                        if (w_col_ok && w_row_ok) begin
                            w_ram_re = 1'b1;
                            n_state  = S_READ;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_READ: begin
                n_cell  = w_ram_rdata;
                n_state = S_FIN;
            end
            S_FIN: begin
                // Hand the result to the output register
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_col   = COL_W'(r_cur_col);
                    n_out_row   = ROW_W'(r_cur_row);
                    n_out_loc   = LOC_W'(w_loc);
                    n_out_cell  = r_cell;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Capture the next item beat
        if (w_in_acc) begin
            n_op     = t_op'(i_operation);
            n_ch     = i_char_code;
            n_attr   = i_attribute;
            n_col_in = i_column;
            n_row_in = i_row;
            n_item   = 1'b0;
            n_state  = S_EXEC;
        end
    end

    // Control state, reset starts the blanking sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_top       <= '0;
            r_cnt       <= '0;
            r_base      <= '0;
            r_last      <= AW'(CELLS - 1);
            r_item      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_top       <= n_top;
            r_cnt       <= n_cnt;
            r_base      <= n_base;
            r_last      <= n_last;
            r_item      <= n_item;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_attr     <= n_attr;
        r_col_in   <= n_col_in;
        r_row_in   <= n_row_in;
        r_cell     <= n_cell;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_loc  <= n_out_loc;
        r_out_cell <= n_out_cell;
    end

    // Screen store, rows kept as a ring
    txcon_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_addr),
        .o_rdata (w_ram_rdata)
    );

    assign o_valid           = r_out_valid;
    assign o_cursor_col_out  = r_out_col;
    assign o_cursor_row_out  = r_out_row;
    assign o_cursor_location = r_out_loc;
    assign o_read_cell       = r_out_cell;

endmodule

`default_nettype wire

@@ src/txcon_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the screen store of the text console. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module txcon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/txcon_chk.sv @@
// Port-level checker for the text console engine, with its bind to the top level.
// Depends on text_console_cursor_scroll only through the bind.
`timescale 1ns / 1ps
`default_nettype none

module txcon_chk #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [6:0]  o_cursor_col_out,
    input wire logic [4:0]  o_cursor_row_out,
    input wire logic [10:0] o_cursor_location,
    input wire logic [15:0] o_read_cell
);

    logic [1:0]  r_open;
    logic [1:0]  n_open;
    logic        w_in_beat;
    logic        w_out_beat;
    logic [13:0] w_exp_loc;

    assign w_in_beat  = i_valid && !o_stall;
    assign w_out_beat = o_valid && !i_stall;

    // Count items accepted but not yet delivered
    always_comb begin
        n_open = r_open;
        if (w_in_beat && !w_out_beat) begin
            n_open = r_open + 2'd1;
        end else if (!w_in_beat && w_out_beat) begin
            n_open = r_open - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= n_open;
        end
    end

    assign w_exp_loc = {9'd0, o_cursor_row_out} * 14'(COLUMNS) + {7'd0, o_cursor_col_out};

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_cursor_col_out, o_cursor_row_out,
                                        o_cursor_location, o_read_cell}))
        else $error("stalled result beat changed");

    // Deliver no result without an accepted item
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> (r_open != 2'd0))
        else $error("result beat without an accepted item");

    // Take at most one item beyond the waiting result, unless that result leaves
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open == 2'd2) && !w_out_beat |-> o_stall)
        else $error("item accepted with two results outstanding");

    // Keep the linear location in step with row and column
    a_loc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((ROWS > 32) || (o_cursor_location == w_exp_loc[10:0])))
        else $error("cursor location disagrees with row and column");

endmodule

bind text_console_cursor_scroll txcon_chk #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_txcon_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_cursor_col_out  (o_cursor_col_out),
    .o_cursor_row_out  (o_cursor_row_out),
    .o_cursor_location (o_cursor_location),
    .o_read_cell       (o_read_cell)
);

`default_nettype wire
